/* src/fcte_pkg.sv */
// ----------------------------------------------------------------------------
// fcte_pkg
// types and constants of the chain table engine
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam logic [15:0] END_MARK = 16'hFFFF;

    localparam logic [2:0] FN_WRITE   = 3'd0;
    localparam logic [2:0] FN_ALLOC   = 3'd1;
    localparam logic [2:0] FN_FREE    = 3'd2;
    localparam logic [2:0] FN_FOLLOW  = 3'd3;
    localparam logic [2:0] FN_APPEND  = 3'd4;
    localparam logic [2:0] FN_RECOUNT = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;

    localparam logic [15:0] DBC_RESET = 16'd4096;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] start_index;
        logic [15:0] entry_value;
        logic [15:0] step_count;
    } t_cmd;

    typedef struct packed {
        logic [15:0] head_index;
        logic [15:0] granted_count;
        logic [15:0] free_count;
        logic [1:0]  status;
    } t_res;

endpackage

/* src/fcte_ram.sv */
// ----------------------------------------------------------------------------
// fcte_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fcte_ram #(
    parameter int W = 16,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/fat_chain_table_engine_unit.sv */
// ----------------------------------------------------------------------------
// fat_chain_table_engine_unit
// chain link table: write, allocate, free, follow, append and recount requests
// ----------------------------------------------------------------------------
// a request word is taken when start is high and busy is low; the result word
// shows on o_res for one cycle with o_done and cannot be held off.
// data_block_count sits at every apb address and is to be written only while
// idle; the user must keep to this, the block does not enforce it. every
// table access goes through one ram read port with registered data, so a walk
// step passes the rd and ev states (and link for a linked allocate step).
// write entry, unused func and free of an empty chain go straight to done;
// allocate and recount scan up to E entries; free, follow and append walk up
// to E links. E is min(data_block_count, TABLE_DEPTH). after reset the table
// is cleared one entry a cycle with busy high; apb writes still work. the
// free counter starts at zero and is only valid after a recount.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fcte_pkg::t_cmd i_cmd,
    output logic           o_done,
    output fcte_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import fcte_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_LINK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_dbc;
    logic [2:0]  r_func, n_func;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_val, n_val;
    logic [15:0] r_steps, n_steps;
    logic [16:0] r_i, n_i;
    logic [15:0] r_prev, n_prev;
    logic        r_first, n_first;
    logic [15:0] r_head, n_head;
    logic [15:0] r_gr, n_gr;
    logic [15:0] r_fc, n_fc;
    logic [1:0]  r_st, n_st;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata, w_rdata;
    logic [16:0]   w_e, w_sum;

    assign w_e = ({1'b0, r_dbc} > DEPTH17) ? DEPTH17 : {1'b0, r_dbc};
    assign w_sum = {1'b0, r_fc} + {1'b0, r_gr};

    fcte_ram #(.W(16), .D(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_raddr = (r_func == FN_ALLOC || r_func == FN_RECOUNT) ? r_i[AW-1:0]
                                                                 : r_cur[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_cur   = r_cur;
        n_val   = r_val;
        n_steps = r_steps;
        n_i     = r_i;
        n_prev  = r_prev;
        n_first = r_first;
        n_head  = r_head;
        n_gr    = r_gr;
        n_fc    = r_fc;
        n_st    = r_st;
        w_we    = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wdata = 16'd0;
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_wdata = (r_i == 17'd0) ? END_MARK : 16'd0;
                n_i     = r_i + 17'd1;
                if (r_i == DEPTH17 - 17'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_cmd.func;
                    n_cur   = i_cmd.start_index;
                    n_val   = i_cmd.entry_value;
                    n_steps = i_cmd.step_count;
                    n_i     = 17'd0;
                    n_first = 1'b1;
                    n_head  = 16'd0;
                    n_gr    = 16'd0;
                    n_st    = ST_OK;
                    n_state = S_RD;
                    case (i_cmd.func)
                        FN_WRITE: begin
                            n_state = S_DONE;
                            if ({1'b0, i_cmd.start_index} < DEPTH17) begin
                                w_we    = 1'b1;
                                w_waddr = i_cmd.start_index[AW-1:0];
                                w_wdata = i_cmd.entry_value;
                            end else begin
                                n_st = ST_RANGE;
                            end
                        end
                        FN_ALLOC: n_head = END_MARK;
                        FN_FREE: begin
                            if (i_cmd.start_index == END_MARK) begin
                                n_state = S_DONE;
                            end
                        end
                        FN_FOLLOW, FN_APPEND, FN_RECOUNT: n_state = S_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                case (r_func)
                    FN_ALLOC: begin
                        if (r_i >= w_e || r_gr >= r_steps) begin
                            n_fc    = (r_fc > r_gr) ? r_fc - r_gr : 16'd0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                    FN_FREE: begin
                        if ({1'b0, r_cur} >= w_e) begin
                            n_st    = ST_RANGE;
                            n_fc    = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                    FN_FOLLOW: begin
                        n_head = r_cur;
                        if (r_i >= {1'b0, r_steps}) begin
                            n_state = S_DONE;
                        end else if (r_i >= w_e) begin
                            n_st    = ST_CHAIN;
                            n_state = S_DONE;
                        end else if ({1'b0, r_cur} >= w_e) begin
                            n_st    = ST_RANGE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                    FN_APPEND: begin
                        n_head = r_cur;
                        if (r_i >= w_e) begin
                            n_st    = ST_CHAIN;
                            n_state = S_DONE;
                        end else if ({1'b0, r_cur} >= w_e) begin
                            n_st    = ST_RANGE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                    default: begin
                        if (r_i >= w_e) begin
                            n_fc    = r_gr;
                            n_gr    = 16'd0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                endcase
            end
            S_EV: begin
                n_state = S_RD;
                case (r_func)
                    FN_ALLOC: begin
                        if (w_rdata == 16'd0) begin
                            w_we    = 1'b1;
                            w_waddr = r_i[AW-1:0];
                            w_wdata = END_MARK;
                            n_gr    = r_gr + 16'd1;
                            if (r_first) begin
                                n_first = 1'b0;
                                n_head  = r_i[15:0];
                                n_prev  = r_i[15:0];
                                n_i     = r_i + 17'd1;
                            end else begin
                                n_state = S_LINK;
                            end
                        end else begin
                            n_i = r_i + 17'd1;
                        end
                    end
                    FN_FREE: begin
                        if (w_rdata == 16'd0) begin
                            n_st    = ST_CHAIN;
                            n_fc    = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                            n_state = S_DONE;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_cur[AW-1:0];
                            w_wdata = 16'd0;
                            n_gr    = r_gr + 16'd1;
                            n_cur   = w_rdata;
                            if (w_rdata == END_MARK) begin
                                n_fc    = (w_sum == 17'h0FFFF || w_sum[16]) ? 16'hFFFF
                                                                           : w_sum[15:0] + 16'd1;
                                n_state = S_DONE;
                            end
                        end
                    end
                    FN_FOLLOW: begin
                        n_cur = w_rdata;
                        n_i   = r_i + 17'd1;
                    end
                    FN_APPEND: begin
                        if (w_rdata == 16'd0) begin
                            n_st    = ST_CHAIN;
                            n_state = S_DONE;
                        end else if (w_rdata == END_MARK) begin
                            w_we    = 1'b1;
                            w_waddr = r_cur[AW-1:0];
                            w_wdata = r_val;
                            n_state = S_DONE;
                        end else begin
                            n_cur = w_rdata;
                            n_i   = r_i + 17'd1;
                        end
                    end
                    default: begin
                        if (w_rdata == 16'd0) begin
                            n_gr = r_gr + 16'd1;
                        end
                        n_i = r_i + 17'd1;
                    end
                endcase
            end
            S_LINK: begin
                w_we    = 1'b1;
                w_waddr = r_prev[AW-1:0];
                w_wdata = r_i[15:0];
                n_prev  = r_i[15:0];
                n_i     = r_i + 17'd1;
                n_state = S_RD;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= 17'd0;
            r_fc    <= 16'd0;
            r_dbc   <= DBC_RESET;
            r_func  <= FN_WRITE;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_fc    <= n_fc;
            r_func  <= n_func;
            if (psel && penable && pwrite) begin
                r_dbc <= pwdata[15:0];
            end
        end
        r_cur   <= n_cur;
        r_val   <= n_val;
        r_steps <= n_steps;
        r_prev  <= n_prev;
        r_first <= n_first;
        r_head  <= n_head;
        r_gr    <= n_gr;
        r_st    <= n_st;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res.head_index    = (r_func == FN_ALLOC || r_func == FN_FOLLOW ||
                                  r_func == FN_APPEND) ? r_head : 16'd0;
    assign o_res.granted_count = (r_func == FN_ALLOC || r_func == FN_FREE) ? r_gr : 16'd0;
    assign o_res.free_count    = r_fc;
    assign o_res.status        = r_st;
    assign prdata = {16'd0, r_dbc};
    assign pready = 1'b1;

    logic w_unused;
    assign w_unused = ^{paddr, pwdata[31:16]};
endmodule

/* src/fcte_chk.sv */
// ----------------------------------------------------------------------------
// fcte_chk
// port level checks of the chain table engine
// ----------------------------------------------------------------------------
module fcte_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input fcte_pkg::t_res o_res
);
    import fcte_pkg::*;

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("done not followed by idle");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.status != 2'd3)
        else $error("bad status");

    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clear pass after reset");
endmodule

bind fat_chain_table_engine_unit fcte_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

/* tb/fat_chain_table_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// fat_chain_table_engine_unit_tb
// self-checking bench for the chain link table engine
// ----------------------------------------------------------------------------
// drives request words through the start/busy handshake, keeps a shadow link
// table with its own free counter and block count, predicts every result word
// and compares it field by field as o_done marks it. directed tests cover
// allocate, free, follow, append, recount, range and loop errors and the
// block count extremes; random phases then run mostly well-formed chains
// under different sender idle rates.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcte_pkg::*;

    localparam int DEPTH = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        o_done;
    t_res        o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] link_mem [DEPTH];
    logic [15:0] free_cnt;
    logic [15:0] block_cnt;
    t_res        expected_res[$];
    logic [15:0] chain_heads[$];
    int          send_idle_pct = 0;
    int          errors = 0;

    fat_chain_table_engine_unit #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_res chain_predict(t_cmd c);
        int   e, i, cur, v, prev, granted;
        bit   first;
        t_res r;
        e = (block_cnt > DEPTH) ? DEPTH : int'(block_cnt);
        r = '0;
        granted = 0;
        case (c.func)
            FN_WRITE: begin
                if (c.start_index < DEPTH) link_mem[c.start_index[11:0]] = c.entry_value;
                else r.status = ST_RANGE;
            end
            FN_ALLOC: begin
                r.head_index = END_MARK;
                prev = 0;
                first = 1'b1;
                for (i = 0; i < e && granted < c.step_count; i++) begin
                    if (link_mem[i] != 0) continue;
                    if (first) begin
                        r.head_index = 16'(i);
                        first = 1'b0;
                    end else begin
                        link_mem[prev] = 16'(i);
                    end
                    link_mem[i] = END_MARK;
                    prev = i;
                    granted++;
                end
                free_cnt = (free_cnt > granted) ? 16'(int'(free_cnt) - granted) : 16'd0;
            end
            FN_FREE: begin
                cur = int'(c.start_index);
                if (cur != END_MARK) begin
                    while (1'b1) begin
                        if (cur >= e) begin
                            r.status = ST_RANGE;
                            break;
                        end
                        v = int'(link_mem[cur]);
                        if (v == 0) begin
                            r.status = ST_CHAIN;
                            break;
                        end
                        link_mem[cur] = '0;
                        granted++;
                        if (v == END_MARK) break;
                        cur = v;
                    end
                    v = int'(free_cnt) + granted;
                    free_cnt = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
                end
            end
            FN_FOLLOW: begin
                cur = int'(c.start_index);
                for (i = 0; i < c.step_count; i++) begin
                    if (i >= e) begin
                        r.status = ST_CHAIN;
                        break;
                    end
                    if (cur >= e) begin
                        r.status = ST_RANGE;
                        break;
                    end
                    cur = int'(link_mem[cur]);
                end
                r.head_index = 16'(cur);
            end
            FN_APPEND: begin
                cur = int'(c.start_index);
                for (i = 0; i <= e; i++) begin
                    if (i >= e) begin
                        r.status = ST_CHAIN;
                        break;
                    end
                    if (cur >= e) begin
                        r.status = ST_RANGE;
                        break;
                    end
                    v = int'(link_mem[cur]);
                    if (v == 0) begin
                        r.status = ST_CHAIN;
                        break;
                    end
                    if (v == END_MARK) begin
                        link_mem[cur] = c.entry_value;
                        break;
                    end
                    cur = v;
                end
                r.head_index = 16'(cur);
            end
            FN_RECOUNT: begin
                v = 0;
                for (i = 0; i < e; i++) if (link_mem[i] == 0) v++;
                free_cnt = 16'(v);
            end
            default: ;
        endcase
        r.granted_count = 16'(granted);
        r.free_count = free_cnt;
        return r;
    endfunction

    task automatic issue_word(logic [2:0] fn, logic [15:0] idx, logic [15:0] val,
                              logic [15:0] cnt);
        t_cmd c;
        t_res r;
        c = '{func: fn, start_index: idx, entry_value: val, step_count: cnt};
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = chain_predict(c);
        expected_res.push_back(r);
        if (fn == FN_ALLOC && r.granted_count != 0) begin
            chain_heads.push_back(r.head_index);
            if (chain_heads.size() > 16) void'(chain_heads.pop_front());
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_block_count(logic [15:0] cnt);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'($urandom), cnt};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        block_cnt = cnt;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== block_cnt)
            report($sformatf("block count read %h, want %h", prdata[15:0], block_cnt));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                report("result word with none expected");
            end else begin
                w = expected_res.pop_front();
                if (o_res.head_index !== w.head_index)
                    report($sformatf("head %h, want %h", o_res.head_index, w.head_index));
                if (o_res.granted_count !== w.granted_count)
                    report($sformatf("granted %h, want %h",
                                     o_res.granted_count, w.granted_count));
                if (o_res.free_count !== w.free_count)
                    report($sformatf("free %h, want %h", o_res.free_count, w.free_count));
                if (o_res.status !== w.status)
                    report($sformatf("status %0d, want %0d", o_res.status, w.status));
            end
        end
    end

    task automatic test_alloc_follow();
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd1);
        issue_word(FN_RECOUNT, 16'd0, 16'd0, 16'd0);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd0);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd2);
        issue_word(FN_FOLLOW, 16'd2, 16'd0, 16'd1);
        issue_word(FN_FOLLOW, 16'd1, 16'd0, 16'hFFFF);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd2);
        issue_word(FN_APPEND, 16'd1, 16'd4, 16'd0);
        issue_word(FN_FREE, 16'd1, 16'd0, 16'd0);
        issue_word(FN_FREE, END_MARK, 16'd0, 16'd0);
    endtask

    task automatic test_errors();
        issue_word(FN_WRITE, 16'hFFFF, 16'hAAAA, 16'hFFFF);
        issue_word(FN_WRITE, 16'd4095, 16'h5555, 16'd0);
        issue_word(FN_WRITE, 16'd4095, 16'hAAAA, 16'd0);
        issue_word(FN_WRITE, 16'd4095, 16'd0, 16'd0);
        issue_word(FN_FREE, 16'd1, 16'd0, 16'd0);
        issue_word(FN_FREE, 16'd5000, 16'd0, 16'd0);
        issue_word(FN_FOLLOW, 16'd5000, 16'd0, 16'd0);
        issue_word(FN_FOLLOW, 16'd5000, 16'd0, 16'd1);
        issue_word(FN_APPEND, 16'd7, 16'd0, 16'd0);
        issue_word(FN_APPEND, 16'd5000, 16'd0, 16'd0);
        issue_word(3'd6, 16'h1234, 16'h5678, 16'h9ABC);
        issue_word(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_loops();
        issue_word(FN_WRITE, 16'd10, 16'd11, 16'd0);
        issue_word(FN_WRITE, 16'd11, 16'd10, 16'd0);
        issue_word(FN_FOLLOW, 16'd10, 16'd0, 16'hFFFF);
        issue_word(FN_APPEND, 16'd10, 16'd0, 16'd0);
        issue_word(FN_FREE, 16'd10, 16'd0, 16'd0);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'hFFFF);
        issue_word(FN_FREE, 16'd1, 16'd0, 16'd0);
    endtask

    task automatic test_block_count_extremes();
        set_block_count(16'd1);
        issue_word(FN_RECOUNT, 16'd0, 16'd0, 16'd0);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd3);
        issue_word(FN_FOLLOW, 16'd0, 16'd0, 16'd3);
        set_block_count(16'hFFFF);
        issue_word(FN_RECOUNT, 16'd0, 16'd0, 16'd0);
        issue_word(FN_ALLOC, 16'd0, 16'd0, 16'd2);
    endtask

    function automatic logic [15:0] pick_index(int e);
        if (chain_heads.size() != 0 && $urandom_range(3) != 0)
            return chain_heads[$urandom_range(chain_heads.size() - 1)];
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'($urandom_range(e - 1));
    endfunction

    task automatic test_random(logic [15:0] cnt, int idle_pct, int n, bit hold_off);
        int          k, e;
        logic [15:0] v;
        set_block_count(cnt);
        send_idle_pct = idle_pct;
        e = int'(cnt);
        for (k = 0; k < n; k++) begin
            if (hold_off && k == n / 2) drain();
            case ($urandom_range(99)) inside
                [0:11]: begin
                    case ($urandom_range(3))
                        0: v = 16'd0;
                        1: v = END_MARK;
                        2: v = 16'($urandom_range(e - 1));
                        default: v = 16'($urandom);
                    endcase
                    issue_word(FN_WRITE, pick_index(e), v, 16'($urandom));
                end
                [12:33]: issue_word(FN_ALLOC, 16'($urandom), 16'($urandom),
                                    ($urandom_range(9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(6)));
                [34:53]: issue_word(FN_FREE, pick_index(e), 16'($urandom), 16'($urandom));
                [54:68]: issue_word(FN_FOLLOW, pick_index(e), 16'($urandom),
                                    ($urandom_range(4) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(8)));
                [69:83]: issue_word(FN_APPEND, pick_index(e), pick_index(e),
                                    16'($urandom));
                [84:91]: issue_word(FN_RECOUNT, 16'($urandom), 16'($urandom),
                                    16'($urandom));
                default: issue_word(3'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom));
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) link_mem[i] = '0;
        link_mem[0] = END_MARK;
        free_cnt = '0;
        block_cnt = DBC_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_alloc_follow();
        test_errors();
        test_loops();
        test_block_count_extremes();
        test_random(16'd24, 33, 40, 1'b1);
        test_random(16'd64, 49, 40, 1'b0);
        test_random(16'd12, 0, 40, 1'b0);
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* fat_chain_table_engine_unit.f */
src/fcte_pkg.sv
src/fcte_ram.sv
src/fat_chain_table_engine_unit.sv
src/fcte_chk.sv
tb/fat_chain_table_engine_unit_tb.sv
